// ----- sv/signed_integer_to_decimal_ascii_assert.svh -----
// Assertion macros used by the signed-integer-to-text serializer.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SITOA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sitoa_pkg.sv -----
// Shared constants and stage types for the signed-integer-to-text pipeline.
// No dependencies.
package sitoa_pkg;

  localparam int VALUE_WIDTH    = 32;
  // Enough decimal digits for a magnitude of 2^(VALUE_WIDTH-1).
  localparam int MAX_DIGITS     = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_STAGES     = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PAD_WIDTH      = NUM_STAGES * BITS_PER_STAGE;
  localparam int BCD_WIDTH      = 4 * MAX_DIGITS;
  localparam int IDX_W          = $clog2(MAX_DIGITS);
  localparam int LEN_W          = 4;
  localparam int CNT_W          = ($clog2(MAX_DIGITS + 2) > LEN_W) ?
                                  $clog2(MAX_DIGITS + 2) : LEN_W;
  localparam int CHAR_W         = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  // Item inside the conversion stages.
  typedef struct packed {
    logic                 neg;
    logic [BCD_WIDTH-1:0] bcd;
    logic [PAD_WIDTH-1:0] bin;
  } pipe_t;

  // Item handed to the character serializer.
  typedef struct packed {
    logic                 neg;
    logic [IDX_W-1:0]     top_idx;
    logic [LEN_W-1:0]     text_length;
    logic [BCD_WIDTH-1:0] bcd;
  } digits_t;

endpackage

// ----- sv/sitoa_dabble_stage.sv -----
// One shift-and-add-3 stage of the binary to BCD conversion.
// Depends on sitoa_pkg.
module sitoa_dabble_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  sitoa_pkg::pipe_t in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output sitoa_pkg::pipe_t out_data_o,
  input  logic             out_ready_i
);

  logic                                valid_q;
  sitoa_pkg::pipe_t                    data_q;
  sitoa_pkg::pipe_t                    data_d;
  logic [sitoa_pkg::BCD_WIDTH-1:0]     bcd;
  logic [sitoa_pkg::PAD_WIDTH-1:0]     bin;

  always_comb begin
    bcd = in_data_i.bcd;
    bin = in_data_i.bin;
    for (int s = 0; s < sitoa_pkg::BITS_PER_STAGE; s++) begin
      for (int d = 0; d < sitoa_pkg::MAX_DIGITS; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      {bcd, bin} = {bcd[sitoa_pkg::BCD_WIDTH-2:0], bin, 1'b0};
    end
    data_d.neg = in_data_i.neg;
    data_d.bcd = bcd;
    data_d.bin = bin;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- sv/sitoa_length.sv -----
// Digit count stage: finds the leading nonzero digit and the text length.
// Depends on sitoa_pkg.
module sitoa_length (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sitoa_pkg::pipe_t   in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output sitoa_pkg::digits_t out_data_o,
  input  logic               out_ready_i
);

  logic                            valid_q;
  sitoa_pkg::digits_t              data_q;
  sitoa_pkg::digits_t              data_d;
  logic [sitoa_pkg::IDX_W-1:0]     top_idx;
  logic [sitoa_pkg::CNT_W-1:0]     len;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < sitoa_pkg::MAX_DIGITS; i++) begin
      if (in_data_i.bcd[4*i +: 4] != 4'd0) begin
        top_idx = sitoa_pkg::IDX_W'(i);
      end
    end
    len = sitoa_pkg::CNT_W'(top_idx) + sitoa_pkg::CNT_W'(1)
        + sitoa_pkg::CNT_W'(in_data_i.neg);
    data_d.neg         = in_data_i.neg;
    data_d.top_idx     = top_idx;
    data_d.text_length = len[sitoa_pkg::LEN_W-1:0];
    data_d.bcd         = in_data_i.bcd;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- sv/sitoa_serializer.sv -----
// Serializer: emits sign and digits into an output register, one per unstalled cycle.
// Depends on sitoa_pkg and signed_integer_to_decimal_ascii_assert.svh.
`include "signed_integer_to_decimal_ascii_assert.svh"

module sitoa_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  sitoa_pkg::digits_t            in_data_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sitoa_pkg::CHAR_W-1:0]  char_code_o,
  output logic [sitoa_pkg::LEN_W-1:0]   text_length_o,
  output logic                          last_o
);

  logic                            busy_q;
  logic                            sign_q;
  logic [sitoa_pkg::IDX_W-1:0]     idx_q;
  logic [sitoa_pkg::LEN_W-1:0]     len_q;
  logic [sitoa_pkg::BCD_WIDTH-1:0] bcd_q;
  logic                            out_valid_q;
  logic [sitoa_pkg::CHAR_W-1:0]    char_q;
  logic [sitoa_pkg::LEN_W-1:0]     out_len_q;
  logic                            last_q;
  logic                            out_adv;
  logic                            emit;
  logic                            finishing;
  logic                            load;
  logic [3:0]                      digit;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign emit       = busy_q && out_adv;
  assign finishing  = emit && !sign_q && (idx_q == '0);
  assign in_ready_o = !busy_q || finishing;
  assign load       = in_valid_i && in_ready_o;
  assign digit      = bcd_q[4*idx_q +: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (finishing) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_adv) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q    <= sign_q ? sitoa_pkg::CH_MINUS : sitoa_pkg::CH_ZERO + {4'd0, digit};
      last_q    <= !sign_q && (idx_q == '0);
      out_len_q <= len_q;
    end
    if (load) begin
      sign_q <= in_data_i.neg;
      idx_q  <= in_data_i.top_idx;
      len_q  <= in_data_i.text_length;
      bcd_q  <= in_data_i.bcd;
    end else if (emit) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        idx_q <= idx_q - sitoa_pkg::IDX_W'(1);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign text_length_o = out_len_q;
  assign last_o        = last_q;

  `SITOA_ASSERT_IMPL(a_char_legal, out_valid_q, (char_q == sitoa_pkg::CH_MINUS) || ((char_q >= sitoa_pkg::CH_ZERO) && (char_q <= sitoa_pkg::CH_ZERO + 8'd9)), "illegal character code")
  `SITOA_ASSERT_IMPL(a_last_is_digit, out_valid_q && last_q, char_q != sitoa_pkg::CH_MINUS, "text ends in a sign")
  `SITOA_ASSERT_IMPL(a_load_when_free, load && busy_q, finishing, "item loaded over unfinished text")
  `SITOA_ASSERT_NEXT(a_sign_then_digit, emit && sign_q, busy_q && !sign_q, "sign not followed by digits")

endmodule

// ----- sv/signed_integer_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal text converter.
// Depends on sitoa_pkg, sitoa_dabble_stage, sitoa_length and sitoa_serializer.
//
// Converts each signed two's-complement value into its decimal text and sends
// the text out one character per item, most significant first: a '-' leads a
// negative value, zero gives a single '0', and no leading zeros appear. Every
// character carries the total text length (sign included) and last marks the
// final character; the most negative value gives its full magnitude. Inside,
// an entry register forms sign and unsigned magnitude, a chain of
// shift-and-add-3 stages (four bits per stage, eight stages at 32 bits) builds
// the BCD digits, a length stage finds the leading digit, and a serializer
// with its own output register emits the characters. Items enter the
// conversion pipeline back to back unless in_stall_o is raised; throughput
// is set by the one-character output channel: a value holds the serializer
// while its text goes out (1 to 11 characters at 32 bits), and the next value
// is taken into the serializer in the cycle its last character goes out. A
// stall at the output backs up through the stages behind it, and no item is
// lost or repeated.
module signed_integer_to_decimal_ascii (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sitoa_pkg::CHAR_W-1:0]          char_code_o,
  output logic [sitoa_pkg::LEN_W-1:0]           text_length_o,
  output logic                                  last_o
);

  // Stage k feeds stage k+1; index 0 is the entry register.
  logic             stg_valid [sitoa_pkg::NUM_STAGES+1];
  logic             stg_ready [sitoa_pkg::NUM_STAGES+1];
  sitoa_pkg::pipe_t stg_data  [sitoa_pkg::NUM_STAGES+1];

  logic [sitoa_pkg::VALUE_WIDTH-1:0] value_u;
  logic [sitoa_pkg::VALUE_WIDTH-1:0] entry_mag;
  logic                              entry_ready;
  logic                              entry_valid_q;
  sitoa_pkg::pipe_t                  entry_q;
  sitoa_pkg::pipe_t                  entry_d;

  logic               len_valid;
  logic               len_ready;
  sitoa_pkg::digits_t len_data;

  // Magnitude taken unsigned, so the most negative value wraps onto itself.
  assign value_u   = value_i;
  assign entry_mag = value_u[sitoa_pkg::VALUE_WIDTH-1] ?
                     (sitoa_pkg::VALUE_WIDTH'(0) - value_u) : value_u;

  always_comb begin
    entry_d.neg = value_u[sitoa_pkg::VALUE_WIDTH-1];
    entry_d.bcd = '0;
    entry_d.bin = sitoa_pkg::PAD_WIDTH'(entry_mag);
  end

  assign entry_ready = !entry_valid_q || stg_ready[0];
  assign in_stall_o  = !entry_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (entry_ready) begin
      entry_valid_q <= in_valid_i;
    end
  end

  // Capture only on an accepted item; hold otherwise.
  always_ff @(posedge clk_i) begin
    if (entry_ready && in_valid_i) begin
      entry_q <= entry_d;
    end
  end

  assign stg_valid[0] = entry_valid_q;
  assign stg_data[0]  = entry_q;

  for (genvar k = 0; k < sitoa_pkg::NUM_STAGES; k++) begin : g_dabble
    sitoa_dabble_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[k]),
      .in_data_i   (stg_data[k]),
      .in_ready_o  (stg_ready[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_data_o  (stg_data[k+1]),
      .out_ready_i (stg_ready[k+1])
    );
  end

  sitoa_length u_length (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[sitoa_pkg::NUM_STAGES]),
    .in_data_i   (stg_data[sitoa_pkg::NUM_STAGES]),
    .in_ready_o  (stg_ready[sitoa_pkg::NUM_STAGES]),
    .out_valid_o (len_valid),
    .out_data_o  (len_data),
    .out_ready_i (len_ready)
  );

  sitoa_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (len_valid),
    .in_data_i     (len_data),
    .in_ready_o    (len_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .text_length_o (text_length_o),
    .last_o        (last_o)
  );

endmodule

// ----- dv/sitoa_text_checker.sv -----
// Watches both channels of signed_integer_to_decimal_ascii, spells each accepted value
// into its expected characters and compares them with the characters that leave.
// Depends on sitoa_pkg for the value width.
module sitoa_text_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [sitoa_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [7:0]                      char_code_i,
  input  logic [3:0]                      text_length_i,
  input  logic                            last_i,
  output int                              error_count_o,
  output int                              chars_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = sitoa_pkg::VALUE_WIDTH;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic [7:0] code;
    logic [3:0] length;
    logic       last;
  } text_char_t;

  text_char_t text_q [$];
  text_char_t want;

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $realtime, what, got, wanted);
    error_count_o++;
  endtask

  // Queue the characters of one value: sign first, then digits most significant first.
  task automatic spell_value(input logic [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [7:0]    digits [$];
    logic          negative;
    logic [3:0]    len;
    text_char_t    ch;
    negative = v[VW-1];
    mag      = negative ? (~v + 1'b1) : v;
    do begin
      digits.push_front(ASCII_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    len = 4'(digits.size() + (negative ? 1 : 0));
    if (negative) begin
      ch = '{code: ASCII_MINUS, length: len, last: 1'b0};
      text_q.push_back(ch);
    end
    foreach (digits[i]) begin
      ch = '{code: digits[i], length: len, last: (i == digits.size() - 1)};
      text_q.push_back(ch);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        spell_value(value_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (text_q.size() == 0) begin
          report_mismatch("unexpected char_code", int'(char_code_i), -1);
        end else begin
          want = text_q.pop_front();
          if (char_code_i !== want.code)
            report_mismatch("char_code", int'(char_code_i), int'(want.code));
          if (text_length_i !== want.length)
            report_mismatch("text_length", int'(text_length_i), int'(want.length));
          if (last_i !== want.last)
            report_mismatch("last", int'(last_i), int'(want.last));
        end
      end
      chars_pending_o = text_q.size();
    end
  end

endmodule

// ----- dv/signed_integer_to_decimal_ascii_test.sv -----
// Top of the signed_integer_to_decimal_ascii testbench: clock, reset, stimulus and verdict.
// Depends on sitoa_pkg, the block itself and sitoa_text_checker.
module signed_integer_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW             = sitoa_pkg::VALUE_WIDTH;
  localparam int RANDOM_ITEMS   = 470;
  localparam int SQUEEZE_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 60;    // block latency plus margin after the last character
  localparam int TIMEOUT_NS     = 2_000_000;

  // Corner values: zero, one-digit, decade edges, both extremes, alternating bits.
  localparam logic [31:0] CORNER_VALUES [0:21] = '{
    0, 1, -1, 7, 9, -9, 10, -10, 99, 100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    999999999, 1000000000, -999999999, -1000000000,
    123456789, -123456789, 2000000000,
    32'h5555_5555, 32'hAAAA_AAAA
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [VW-1:0] value;
  logic          out_valid;
  logic          out_stall;
  logic [7:0]    char_code;
  logic [3:0]    text_length;
  logic          last_char;
  int            error_count;
  int            chars_pending;
  bit            squeeze_pending = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_integer_to_decimal_ascii i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .char_code_o   (char_code),
    .text_length_o (text_length),
    .last_o        (last_char)
  );

  sitoa_text_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .char_code_i     (char_code),
    .text_length_i   (text_length),
    .last_i          (last_char),
    .error_count_o   (error_count),
    .chars_pending_o (chars_pending)
  );

  // Offer one item from a falling edge and hold it until accepted; return on the
  // falling edge after acceptance so the caller can chain the next item without
  // dropping valid.
  task automatic offer_value(input logic [VW-1:0] v);
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a value: mostly a uniformly chosen digit count with random digits,
  // sometimes raw random bits, sometimes a value next to either extreme.
  function automatic logic [VW-1:0] random_value();
    int          pick;
    int          digit_count;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mag;
    pick = $urandom_range(0, 9);
    if (pick < 2) return $urandom();
    if (pick == 2) begin
      return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 20)
                                  : 32'h8000_0000 + $urandom_range(0, 20);
    end
    digit_count = $urandom_range(1, 10);
    lo = 1;
    repeat (digit_count - 1) lo = lo * 10;
    hi = (digit_count == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
    if (digit_count == 1) lo = 0;
    mag = $urandom_range(hi, lo);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Sender: reset, directed corners back to back, then random bursts with gaps.
  initial begin : stimulus
    int sent;
    int burst_len;
    int gap_len;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    value    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (CORNER_VALUES[i]) offer_value(CORNER_VALUES[i]);

    // Ask for a long receiver hold-off while the sender keeps pushing, so the
    // pipeline fills and the block stalls its input.
    squeeze_pending = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 30);
      for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
        offer_value(random_value());
        sent++;
      end
      if (sent == RANDOM_ITEMS / 2) squeeze_pending = 1'b1;
      // Skip the gap now and then so some bursts run into each other.
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    // Wait for every expected character, then give stray ones time to show up.
    while (chars_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && chars_pending == 0) begin
      $display("signed_integer_to_decimal_ascii test passed");
    end else begin
      $display("signed_integer_to_decimal_ascii test failed");
    end
    $finish;
  end

  // Receiver: stall on runs of a randomly chosen pattern; serve a hold-off
  // request as one long stretch of stall.
  initial begin : receiver
    stall_mode_e mode;
    int          run_len;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        repeat (SQUEEZE_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode    = stall_mode_e'($urandom_range(0, 3));
      run_len = $urandom_range(20, 120);
      for (int step = 0; step < run_len; step++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 4) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= (step % 5 >= 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("signed_integer_to_decimal_ascii test failed");
    $finish;
  end

endmodule
